FILE: rtl/core/c_esc_pkg.sv
`default_nettype none

package c_esc_pkg;

    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;

    // Escape letters and the bytes they stand for.
    localparam logic [BYTE_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CH_N         = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R         = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T         = 8'h74;
    localparam logic [BYTE_W-1:0] CH_X         = 8'h78;
    localparam logic [BYTE_W-1:0] VAL_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] VAL_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] VAL_TAB      = 8'h09;

    // Input item kinds.
    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [1:0] {
        MODE_TEXT = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_HEX0 = 2'd2,
        MODE_HEX1 = 2'd3
    } t_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              has_byte;
        logic              is_end;
    } t_result;

    typedef struct packed {
        logic             valid;
        logic [NIB_W-1:0] value;
    } t_hex;

    // Classifies one byte as a hex digit of either case.
    function automatic t_hex hex_decode(input logic [BYTE_W-1:0] b);
        t_hex h;
        h.valid = 1'b1;
        h.value = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = NIB_W'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = NIB_W'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = NIB_W'(b - 8'h57);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/c_esc_if.sv
`default_nettype none

// Escaped input stream: one byte or an end mark per transfer.
interface c_esc_in_if;
    import c_esc_pkg::*;

    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, kind, in_byte, input ready);
    modport sink   (input valid, kind, in_byte, output ready);
endinterface

// Decoded output stream: one result per transfer.
interface c_esc_out_if;
    import c_esc_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              has_byte;
    logic              is_end;

    modport source (output valid, out_byte, has_byte, is_end, input ready);
    modport sink   (input valid, out_byte, has_byte, is_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/c_escape_decoder_core.sv
// C escape-sequence decoder.
// The input channel carries one escaped text byte or an end-of-string mark per
// transfer. The output channel carries one decoded result per transfer: a byte
// with has_byte set, or on an end mark a closing result with is_end set that
// also carries a still open hex value.
// An accepted item sits in an input register, is decoded there and its zero,
// one or two results are written into a two-entry output queue, whose head
// drives the output. The block takes one item per cycle while the queue has
// room; an item that gives two results (a hex value closed by a non-hex byte
// other than a backslash) sends both through the output port, so the output
// port sets the sustained rate at one result per cycle while the receiver is
// ready.
// Reset returns the decoder to plain text mode, clears the pending hex digit
// and empties both the input register and the output queue.
// When the receiver stalls, the queue fills and the input register holds its
// item until the queue has room for all of its results; the input ready then
// drops, and no result is lost or reordered.
`default_nettype none

module c_escape_decoder_core (
    input  wire          i_clk,
    input  wire          i_rst_n,
    c_esc_in_if.sink     i_in,
    c_esc_out_if.source  o_out
);
    import c_esc_pkg::*;

    // Input register.
    logic              r_in_valid;
    logic              r_kind;
    logic [BYTE_W-1:0] r_byte;

    // Decoder state.
    t_mode             r_mode;
    t_mode             n_mode;
    logic [NIB_W-1:0]  r_nib;
    logic [NIB_W-1:0]  n_nib;

    // Output queue, head at entry 0.
    t_result           r_q [2];
    t_result           n_q [2];
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;

    // Results of the item in the input register.
    t_result           res0;
    t_result           res1;
    logic [1:0]        res_n;
    t_hex              hex;

    logic              pop;
    logic              room;
    logic              fire;
    logic [2:0]        fill;

    // Decode of the held item against the current state.
    always_comb begin
        hex    = hex_decode(r_byte);
        res0   = '{out_byte: r_byte, has_byte: 1'b1, is_end: 1'b0};
        res1   = '{out_byte: r_byte, has_byte: 1'b1, is_end: 1'b0};
        res_n  = 2'd0;
        n_mode = r_mode;
        n_nib  = r_nib;
        if (r_kind == KIND_END) begin
            // Close the string; an open hex value rides on the final result.
            res0.is_end   = 1'b1;
            res0.has_byte = (r_mode == MODE_HEX0) || (r_mode == MODE_HEX1);
            res0.out_byte = (r_mode == MODE_HEX1) ? BYTE_W'(r_nib) : '0;
            res_n         = 2'd1;
            n_mode        = MODE_TEXT;
            n_nib         = '0;
        end else begin
            unique case (r_mode)
                MODE_TEXT: begin
                    if (r_byte == CH_BACKSLASH) begin
                        n_mode = MODE_ESC;
                    end else begin
                        res_n = 2'd1;
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_TEXT;
                    res_n  = 2'd1;
                    unique case (r_byte)
                        CH_N:         res0.out_byte = VAL_LF;
                        CH_R:         res0.out_byte = VAL_CR;
                        CH_T:         res0.out_byte = VAL_TAB;
                        CH_X: begin
                            n_mode = MODE_HEX0;
                            n_nib  = '0;
                            res_n  = 2'd0;
                        end
                        // Quote, backslash and unknown letters pass through.
                        default:      res0.out_byte = r_byte;
                    endcase
                end
                MODE_HEX0, MODE_HEX1: begin
                    if (hex.valid) begin
                        if (r_mode == MODE_HEX0) begin
                            n_nib  = hex.value;
                            n_mode = MODE_HEX1;
                        end else begin
                            res0.out_byte = {r_nib, hex.value};
                            res_n         = 2'd1;
                            n_mode        = MODE_TEXT;
                            n_nib         = '0;
                        end
                    end else begin
                        // A non-hex byte closes the value and is decoded afresh.
                        res0.out_byte = (r_mode == MODE_HEX1) ? BYTE_W'(r_nib) : '0;
                        n_nib         = '0;
                        if (r_byte == CH_BACKSLASH) begin
                            n_mode = MODE_ESC;
                            res_n  = 2'd1;
                        end else begin
                            n_mode = MODE_TEXT;
                            res_n  = 2'd2;
                        end
                    end
                end
            endcase
        end
    end

    // Handshake: the held item moves on only when all its results fit.
    assign pop  = (r_cnt != 2'd0) && o_out.ready;
    assign fill = 3'(r_cnt) - 3'(pop) + 3'(res_n);
    assign room = (fill <= 3'd2);
    assign fire = r_in_valid && room;

    assign i_in.ready     = !r_in_valid || room;
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_q[0].out_byte;
    assign o_out.has_byte = r_q[0].has_byte;
    assign o_out.is_end   = r_q[0].is_end;

    // Queue update: pop at the head, then append this item's results.
    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 2'd1;
        end
        if (fire) begin
            if (res_n != 2'd0) begin
                n_q[n_cnt[0]] = res0;
            end
            if (res_n == 2'd2) begin
                n_q[1] = res1;
            end
            n_cnt = n_cnt + res_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_TEXT;
            r_nib      <= '0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_mode <= n_mode;
                r_nib  <= n_nib;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_kind <= i_in.kind;
            r_byte <= i_in.in_byte;
        end
        r_q <= n_q;
    end

    // The queue never holds more than its two entries.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("output queue overflow");

    // An end mark always leaves the decoder in plain text mode with no digit.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_kind == KIND_END) |=> (r_mode == MODE_TEXT && r_nib == '0))
        else $error("end mark did not restore text mode");

    // The second-digit mode is only entered from the first-digit mode.
    a_hex_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HEX1 && $past(r_mode) != MODE_HEX1)
            |-> $past(r_mode) == MODE_HEX0)
        else $error("hex digit mode entered out of order");

    // A held item that cannot move on keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_byte) && $stable(r_kind)))
        else $error("held input item was lost");

endmodule

`default_nettype wire

FILE: verif/c_escape_decoder_core_tb.sv
`timescale 1ns / 100ps

// Testbench for the C escape-sequence decoder core.
// A short directed part walks through every escape letter, hex values with
// zero, one and two digits of either case, early hex termination and the
// end-of-string flush. Random strings follow in three phases with different
// idle patterns on the sender and the receiver. Every accepted input is run
// through a local decoder model whose expected results are compared in order
// against every output transfer.
module c_escape_decoder_core_tb;
    import c_esc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_SHOWN    = 10;
    localparam int PHASE_ITEMS  = 340;

    // Escape letters that map to a fixed byte, and the bytes just outside the
    // hex digit ranges, which must close an open hex value.
    localparam logic [BYTE_W-1:0] ESC_LETTERS [5] = '{CH_N, CH_R, CH_T, CH_QUOTE, CH_BACKSLASH};
    localparam logic [BYTE_W-1:0] HEX_NEIGHBORS [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    c_esc_in_if  in_if ();
    c_esc_out_if out_if ();

    c_escape_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Local copy of the decoder state and the results it still owes.
    t_mode             dec_mode   = MODE_TEXT;
    logic [NIB_W-1:0]  dec_nibble = '0;
    t_result           pending_decoded [$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int items_sent    = 0;
    int strings_sent  = 0;
    int results_seen  = 0;
    int err_count     = 0;
    int cycle_count   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a correct run finishes far below this limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_decoded.size());
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls at random with the current percentage.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic note_failure(input string msg);
        err_count++;
        if (err_count <= MAX_SHOWN) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    function automatic void queue_decoded(input logic [BYTE_W-1:0] value, input logic has,
                                          input logic last);
        pending_decoded.push_back(t_result'{value, has, last});
    endfunction

    // Decoder model: updates the local state for one accepted item and queues
    // the zero, one or two results that it causes.
    function automatic void decode_escape(input logic kind, input logic [BYTE_W-1:0] b);
        logic [NIB_W:0] digit;
        logic           as_text;
        as_text = 1'b0;
        // A value of 16 marks a byte that is not a hex digit.
        if (b >= 8'h30 && b <= 8'h39) begin
            digit = {1'b0, b[3:0]};
        end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
            digit = {1'b0, b[3:0]} + 5'd9;
        end else begin
            digit = 5'd16;
        end

        if (kind == KIND_END) begin
            // An open hex value is flushed with the end result; a lone
            // backslash left over is simply dropped.
            case (dec_mode)
                MODE_HEX0: queue_decoded('0, 1'b1, 1'b1);
                MODE_HEX1: queue_decoded(BYTE_W'(dec_nibble), 1'b1, 1'b1);
                default:   queue_decoded('0, 1'b0, 1'b1);
            endcase
            dec_mode   = MODE_TEXT;
            dec_nibble = '0;
        end else begin
            case (dec_mode)
                MODE_ESC: begin
                    dec_mode = MODE_TEXT;
                    case (b)
                        CH_N: queue_decoded(VAL_LF, 1'b1, 1'b0);
                        CH_R: queue_decoded(VAL_CR, 1'b1, 1'b0);
                        CH_T: queue_decoded(VAL_TAB, 1'b1, 1'b0);
                        CH_X: begin
                            dec_mode   = MODE_HEX0;
                            dec_nibble = '0;
                        end
                        // Quote and backslash stand for themselves, just like
                        // any unknown escape character.
                        default: queue_decoded(b, 1'b1, 1'b0);
                    endcase
                end
                MODE_HEX0, MODE_HEX1: begin
                    if (digit < 5'd16 && dec_mode == MODE_HEX0) begin
                        dec_nibble = digit[NIB_W-1:0];
                        dec_mode   = MODE_HEX1;
                    end else if (digit < 5'd16) begin
                        queue_decoded({dec_nibble, digit[NIB_W-1:0]}, 1'b1, 1'b0);
                        dec_mode   = MODE_TEXT;
                        dec_nibble = '0;
                    end else begin
                        // A non-hex byte closes the value and is then decoded
                        // again as plain text.
                        queue_decoded(dec_mode == MODE_HEX1 ? BYTE_W'(dec_nibble) : '0,
                                      1'b1, 1'b0);
                        dec_mode   = MODE_TEXT;
                        dec_nibble = '0;
                        as_text    = 1'b1;
                    end
                end
                default: as_text = 1'b1;
            endcase

            if (as_text) begin
                if (b == CH_BACKSLASH) begin
                    dec_mode = MODE_ESC;
                end else begin
                    queue_decoded(b, 1'b1, 1'b0);
                end
            end
        end
    endfunction

    // Every output transfer is checked against the oldest expected result.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (pending_decoded.size() == 0) begin
                note_failure($sformatf("unexpected result byte=%02h has=%0b end=%0b",
                                       out_if.out_byte, out_if.has_byte, out_if.is_end));
            end else begin
                want = pending_decoded.pop_front();
                if (out_if.out_byte !== want.out_byte || out_if.has_byte !== want.has_byte ||
                    out_if.is_end !== want.is_end) begin
                    note_failure($sformatf(
                        "expected byte=%02h has=%0b end=%0b, got byte=%02h has=%0b end=%0b",
                        want.out_byte, want.has_byte, want.is_end,
                        out_if.out_byte, out_if.has_byte, out_if.is_end));
                end
            end
        end
    end

    // Presents one item, with random idle cycles ahead of it, and returns at
    // the edge where it is transferred. Valid is left high so that the next
    // item can follow back to back; idle cycles and the drain lower it.
    task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid   <= 1'b0;
            in_if.kind    <= 1'($urandom);
            in_if.in_byte <= BYTE_W'($urandom);
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.kind    <= kind;
        in_if.in_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) begin
            @(posedge i_clk);
        end
        items_sent++;
        decode_escape(kind, b);
    endtask

    task automatic send_escape(input logic [BYTE_W-1:0] c);
        send_item(KIND_TEXT, CH_BACKSLASH);
        send_item(KIND_TEXT, c);
    endtask

    task automatic send_end();
        send_item(KIND_END, BYTE_W'($urandom));
        strings_sent++;
    endtask

    // Holds the input idle until every expected result has come out. It waits
    // on an edge before it checks, so valid is never lowered and raised in one step.
    task automatic wait_all_decoded();
        in_if.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_decoded.size() != 0);
    endtask

    function automatic logic [BYTE_W-1:0] hex_char(input logic [NIB_W-1:0] v, input logic upper);
        if (v < 4'd10) begin
            return 8'h30 + BYTE_W'(v);
        end
        return (upper ? 8'h41 : 8'h61) + BYTE_W'(v) - 8'd10;
    endfunction

    task automatic test_plain_and_letters();
        // A zero byte is ordinary data, not a string terminator.
        send_item(KIND_TEXT, 8'h00);
        send_escape(CH_N);
        send_escape(CH_R);
        send_escape(CH_T);
        send_escape(CH_QUOTE);
        send_escape(CH_BACKSLASH);
        // Unknown escape: the backslash is dropped, the byte passes through.
        send_escape(8'hFF);
    endtask

    task automatic test_hex_values();
        // Two digits of mixed case.
        send_escape(CH_X);
        send_item(KIND_TEXT, hex_char(4'hA, 1'b1));
        send_item(KIND_TEXT, hex_char(4'hF, 1'b0));
        // No digit, closed by a backslash that is then left dangling at the
        // end of the string.
        send_escape(CH_X);
        send_item(KIND_TEXT, CH_BACKSLASH);
        send_end();
        // One digit, closed by the byte just past the lowercase digit range.
        send_escape(CH_X);
        send_item(KIND_TEXT, hex_char(4'h5, 1'b0));
        send_item(KIND_TEXT, 8'h67);
        // End in plain text mode carries no byte.
        send_end();
    endtask

    task automatic test_end_flush();
        send_escape(CH_X);
        send_item(KIND_TEXT, hex_char(4'h7, 1'b1));
        send_end();
        send_escape(CH_X);
        send_end();
    endtask

    // Mostly well-formed escape sequences with random content, mixed with raw
    // bytes, lone backslashes and stray items of random kind.
    task automatic send_random_string();
        int n_tokens;
        int pick;
        int n_digits;
        n_tokens = $urandom_range(1, 12);
        repeat (n_tokens) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                send_item(KIND_TEXT, BYTE_W'($urandom));
            end else if (pick < 45) begin
                send_escape(ESC_LETTERS[$urandom_range(4)]);
            end else if (pick < 75) begin
                send_escape(CH_X);
                n_digits = $urandom_range(2);
                repeat (n_digits) begin
                    send_item(KIND_TEXT, hex_char(NIB_W'($urandom), 1'($urandom)));
                end
                if (n_digits < 2 && $urandom_range(1) == 0) begin
                    send_item(KIND_TEXT, HEX_NEIGHBORS[$urandom_range(5)]);
                end
            end else if (pick < 85) begin
                send_escape(BYTE_W'($urandom));
            end else if (pick < 92) begin
                send_item(KIND_TEXT, CH_BACKSLASH);
            end else begin
                send_item(1'($urandom), BYTE_W'($urandom));
            end
        end
        send_end();
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct, input bit drain_midway);
        int stop_at;
        int half_way;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        stop_at  = items_sent + PHASE_ITEMS;
        half_way = items_sent + PHASE_ITEMS / 2;
        while (items_sent < stop_at) begin
            send_random_string();
            if (drain_midway && items_sent >= half_way) begin
                wait_all_decoded();
                drain_midway = 1'b0;
            end
        end
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(27, 62, 1'b1);
    endtask

    task automatic test_random_receiver_idle();
        run_random_phase(62, 27, 1'b0);
    endtask

    task automatic test_random_no_idle();
        run_random_phase(0, 0, 1'b0);
    endtask

    initial begin
        in_if.valid   = 1'b0;
        in_if.kind    = KIND_TEXT;
        in_if.in_byte = '0;
        out_if.ready  = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed part runs with the idle pattern of the first phase.
        src_idle_pct  = 27;
        sink_idle_pct = 62;
        test_plain_and_letters();
        test_hex_values();
        test_end_flush();

        test_random_sender_idle();
        test_random_receiver_idle();
        test_random_no_idle();

        // Let everything drain, then watch a little longer for stray results.
        wait_all_decoded();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items in %0d strings and checked %0d decoded results.",
                 items_sent, strings_sent, results_seen);
        $display("Escape letters, hex values, early hex close and end flush were run %s",
                 "under sender, receiver and no idling.");
        if (err_count == 0 && pending_decoded.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches, %0d results outstanding.", err_count,
                     pending_decoded.size());
            $display("simulation failed");
        end
        $finish;
    end

endmodule
